/* hdl/glm_pkg.sv */
// ----------------------------------------------------------------------------
// glm_pkg
// shared types, grid constants, microcode table and cell address helpers
// ----------------------------------------------------------------------------
package glm_pkg;

    localparam int GRID_ROWS  = 16;
    localparam int GRID_COLS  = 16;
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COORD_W    = 4;
    localparam int HEIGHT_W   = 16;
    localparam int MOVES_W    = 8;
    localparam int STEP_W     = 4;

    // named program counter values; idle, round and emit are jump targets
    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] ST_ROUND  = 4'd1;
    localparam logic [STEP_W-1:0] ST_FLUSH  = 4'd11;
    localparam logic [STEP_W-1:0] ST_DECIDE = 4'd12;
    localparam logic [STEP_W-1:0] ST_EMIT   = 4'd13;

    localparam logic [MOVES_W-1:0] MOVES_MAX = '1;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_DECIDE,
        SEQ_EMIT
    } seq_op_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_INIT,
        CAP_CMP
    } cap_op_t;

    typedef struct packed {
        seq_op_t            seq;
        logic               rd_en;
        logic signed [1:0]  dr;
        logic signed [1:0]  dc;
        cap_op_t            cap;
        logic [STEP_W-1:0]  target;
    } uword_t;

    // actions decoded from the current control word and status
    typedef struct packed {
        logic               in_ready;
        logic               ld_start;
        logic               ld_cell;
        logic               move;
        logic               emit;
        logic               rd_en;
        logic signed [1:0]  dr;
        logic signed [1:0]  dc;
        cap_op_t            cap;
    } act_t;

    typedef struct packed {
        logic in_fire;
        logic in_climb;
        logic start_ok;
        logic stay;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic stay;
        logic out_free;
    } dp_stat_t;

    function automatic uword_t mk_word(seq_op_t seq, logic rd_en, logic signed [1:0] dr,
                                       logic signed [1:0] dc, cap_op_t cap,
                                       logic [STEP_W-1:0] target);
        uword_t w;
        w.seq    = seq;
        w.rd_en  = rd_en;
        w.dr     = dr;
        w.dc     = dc;
        w.cap    = cap;
        w.target = target;
        return w;
    endfunction

    // climb program: read center, then the nine window cells in row-major
    // order, each compare one step behind its read
    function automatic uword_t ucode(logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            4'd0:    w = mk_word(SEQ_WAIT_IN, 1'b0,  2'sd0,  2'sd0, CAP_NONE, ST_EMIT);
            4'd1:    w = mk_word(SEQ_NEXT,    1'b1,  2'sd0,  2'sd0, CAP_NONE, ST_IDLE);
            4'd2:    w = mk_word(SEQ_NEXT,    1'b1, -2'sd1, -2'sd1, CAP_INIT, ST_IDLE);
            4'd3:    w = mk_word(SEQ_NEXT,    1'b1, -2'sd1,  2'sd0, CAP_CMP,  ST_IDLE);
            4'd4:    w = mk_word(SEQ_NEXT,    1'b1, -2'sd1,  2'sd1, CAP_CMP,  ST_IDLE);
            4'd5:    w = mk_word(SEQ_NEXT,    1'b1,  2'sd0, -2'sd1, CAP_CMP,  ST_IDLE);
            4'd6:    w = mk_word(SEQ_NEXT,    1'b1,  2'sd0,  2'sd0, CAP_CMP,  ST_IDLE);
            4'd7:    w = mk_word(SEQ_NEXT,    1'b1,  2'sd0,  2'sd1, CAP_CMP,  ST_IDLE);
            4'd8:    w = mk_word(SEQ_NEXT,    1'b1,  2'sd1, -2'sd1, CAP_CMP,  ST_IDLE);
            4'd9:    w = mk_word(SEQ_NEXT,    1'b1,  2'sd1,  2'sd0, CAP_CMP,  ST_IDLE);
            4'd10:   w = mk_word(SEQ_NEXT,    1'b1,  2'sd1,  2'sd1, CAP_CMP,  ST_IDLE);
            4'd11:   w = mk_word(SEQ_NEXT,    1'b0,  2'sd0,  2'sd0, CAP_CMP,  ST_IDLE);
            4'd12:   w = mk_word(SEQ_DECIDE,  1'b0,  2'sd0,  2'sd0, CAP_NONE, ST_EMIT);
            4'd13:   w = mk_word(SEQ_EMIT,    1'b0,  2'sd0,  2'sd0, CAP_NONE, ST_IDLE);
            default: w = mk_word(SEQ_NEXT,    1'b0,  2'sd0,  2'sd0, CAP_NONE, ST_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic in_grid(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        return (int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] r,
                                                    logic [COORD_W-1:0] c);
        return ADDR_W'(int'(r) * GRID_COLS + int'(c));
    endfunction

endpackage

/* hdl/glm_ram.sv */
// ----------------------------------------------------------------------------
// glm_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
module glm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/glm_useq.sv */
// ----------------------------------------------------------------------------
// glm_useq
// microcode sequencer: step counter, control rom and conditional jumps
// ----------------------------------------------------------------------------
module glm_useq
    import glm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  stat_t             stat,
    output act_t              act,
    output logic [STEP_W-1:0] step
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uword_t            word;

    assign word = ucode(step_reg);
    assign step = step_reg;

    // next step
    always_comb begin
        step_next = step_reg + 1'b1;
        unique case (word.seq)
            SEQ_WAIT_IN: begin
                if (stat.in_fire && stat.in_climb) begin
                    step_next = stat.start_ok ? ST_ROUND : word.target;
                end else begin
                    step_next = step_reg;
                end
            end
            SEQ_DECIDE: step_next = stat.stay ? word.target : ST_ROUND;
            SEQ_EMIT:   step_next = stat.out_free ? word.target : step_reg;
            default:    step_next = step_reg + 1'b1;
        endcase
    end

    // action decode
    always_comb begin
        act.in_ready = (word.seq == SEQ_WAIT_IN);
        act.ld_start = (word.seq == SEQ_WAIT_IN) && stat.in_fire && stat.in_climb;
        act.ld_cell  = (word.seq == SEQ_WAIT_IN) && stat.in_fire && !stat.in_climb;
        act.move     = (word.seq == SEQ_DECIDE) && !stat.stay;
        act.emit     = (word.seq == SEQ_EMIT) && stat.out_free;
        act.rd_en    = word.rd_en;
        act.dr       = word.dr;
        act.dc       = word.dc;
        act.cap      = word.cap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* hdl/glm_datapath.sv */
// ----------------------------------------------------------------------------
// glm_datapath
// grid store, position and candidate registers, compare and result register
// ----------------------------------------------------------------------------
module glm_datapath
    import glm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  act_t                       act,
    input  logic [COORD_W-1:0]         in_row,
    input  logic [COORD_W-1:0]         in_col,
    input  logic signed [HEIGHT_W-1:0] in_height,
    input  logic                       out_ready,
    output dp_stat_t                   dstat,
    output logic                       out_valid,
    output logic [COORD_W-1:0]         out_row,
    output logic [COORD_W-1:0]         out_col,
    output logic signed [HEIGHT_W-1:0] out_height,
    output logic [MOVES_W-1:0]         out_moves
);

    logic [COORD_W-1:0]         pos_row_reg,  pos_col_reg;
    logic [COORD_W-1:0]         best_row_reg, best_col_reg;
    logic signed [HEIGHT_W-1:0] best_h_reg;
    logic [MOVES_W-1:0]         moves_reg;
    logic                       rd_vld_reg;
    logic [COORD_W-1:0]         rd_row_reg, rd_col_reg;
    logic                       m_valid_reg;
    logic [COORD_W-1:0]         o_row_reg, o_col_reg;
    logic signed [HEIGHT_W-1:0] o_h_reg;
    logic [MOVES_W-1:0]         o_moves_reg;

    logic signed [COORD_W+1:0]  nr, nc;
    logic                       nbr_ok;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_addr;
    logic [HEIGHT_W-1:0]        ram_rdata;
    logic signed [HEIGHT_W-1:0] rd_h;
    logic                       higher;

    // neighbor coordinate, range checked so that reads off the grid never win a compare
    always_comb begin
        nr     = signed'({2'b00, pos_row_reg}) + {{COORD_W{act.dr[1]}}, act.dr};
        nc     = signed'({2'b00, pos_col_reg}) + {{COORD_W{act.dc[1]}}, act.dc};
        nbr_ok = !nr[COORD_W+1] && !nc[COORD_W+1]
                 && (int'(nr) < GRID_ROWS) && (int'(nc) < GRID_COLS);
    end

    assign ram_we   = act.ld_cell && in_grid(in_row, in_col);
    assign ram_addr = act.ld_cell ? cell_addr(in_row, in_col)
                                  : cell_addr(nr[COORD_W-1:0], nc[COORD_W-1:0]);

    glm_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_height),
        .rdata (ram_rdata)
    );

    assign rd_h   = signed'(ram_rdata);
    assign higher = rd_vld_reg && (rd_h > best_h_reg);

    always_ff @(posedge aclk) begin
        if (act.rd_en) begin
            rd_vld_reg <= nbr_ok;
            rd_row_reg <= nr[COORD_W-1:0];
            rd_col_reg <= nc[COORD_W-1:0];
        end

        if (act.ld_start) begin
            pos_row_reg  <= in_row;
            pos_col_reg  <= in_col;
            best_row_reg <= in_row;
            best_col_reg <= in_col;
            best_h_reg   <= '0;
            moves_reg    <= '0;
        end else if (act.move) begin
            pos_row_reg <= best_row_reg;
            pos_col_reg <= best_col_reg;
            if (moves_reg != MOVES_MAX) begin
                moves_reg <= moves_reg + 1'b1;
            end
        end else begin
            case (act.cap)
                CAP_INIT: begin
                    best_h_reg   <= rd_h;
                    best_row_reg <= pos_row_reg;
                    best_col_reg <= pos_col_reg;
                end
                CAP_CMP: begin
                    if (higher) begin
                        best_h_reg   <= rd_h;
                        best_row_reg <= rd_row_reg;
                        best_col_reg <= rd_col_reg;
                    end
                end
                default: ;
            endcase
        end

        if (act.emit) begin
            o_row_reg   <= best_row_reg;
            o_col_reg   <= best_col_reg;
            o_h_reg     <= best_h_reg;
            o_moves_reg <= moves_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (act.emit) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign dstat.stay     = (best_row_reg == pos_row_reg) && (best_col_reg == pos_col_reg);
    assign dstat.out_free = !m_valid_reg || out_ready;

    assign out_valid  = m_valid_reg;
    assign out_row    = o_row_reg;
    assign out_col    = o_col_reg;
    assign out_height = o_h_reg;
    assign out_moves  = o_moves_reg;

endmodule

/* hdl/grid_local_maximum_climb_core.sv */
// ----------------------------------------------------------------------------
// grid_local_maximum_climb_core
// 8-neighbor hill climb over a grid of signed 16-bit heights
// ----------------------------------------------------------------------------
// input channel (s_*): one beat per item. op 0 writes s_height into the cell
//   at s_cell_row/s_cell_col (cells outside the grid are dropped), op 1
//   starts a climb from that cell. output channel (m_*): one beat per climb
//   with the end cell, its height and the number of moves, none per load.
// a load keeps the block in the idle step, ready for the next beat.
// a climb runs rounds set by the single ram port: one center read, nine
//   window reads with each compare in the cycle after its read, one flush
//   compare and one decision step. a climb occupies the input until its
//   result is emitted, then the result sits in the output register and the
//   block goes back to taking beats. a climb from outside the grid reports
//   at once with height 0 and move count 0.
// if the receiver stalls, the result waits in the output register while the
//   next beats are taken; a later climb holds in its emit step until the
//   register frees.
// reset (aresetn low, synchronous) returns the sequencer to idle and drops
//   any pending result; the grid store keeps whatever it held and cells are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module grid_local_maximum_climb_core
    import glm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [COORD_W-1:0]         s_cell_row,
    input  logic [COORD_W-1:0]         s_cell_col,
    input  logic signed [HEIGHT_W-1:0] s_height,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COORD_W-1:0]         m_end_row,
    output logic [COORD_W-1:0]         m_end_col,
    output logic signed [HEIGHT_W-1:0] m_peak_height,
    output logic [MOVES_W-1:0]         m_move_count
);

    act_t              act;
    stat_t             stat;
    dp_stat_t          dstat;
    logic [STEP_W-1:0] step;
    logic              in_fire;

    // input beat is taken only in the idle step
    assign s_ready = act.in_ready;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        stat.in_fire  = in_fire;
        stat.in_climb = s_op;
        stat.start_ok = in_grid(s_cell_row, s_cell_col);
        stat.stay     = dstat.stay;
        stat.out_free = dstat.out_free;
    end

    // sequencer: step counter walking the climb program
    glm_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .act     (act),
        .step    (step)
    );

    // datapath: grid store, candidate tracking, result register
    glm_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .act        (act),
        .in_row     (s_cell_row),
        .in_col     (s_cell_col),
        .in_height  (s_height),
        .out_ready  (m_ready),
        .dstat      (dstat),
        .out_valid  (m_valid),
        .out_row    (m_end_row),
        .out_col    (m_end_col),
        .out_height (m_peak_height),
        .out_moves  (m_move_count)
    );

    // ram reads belong to a climb and never overlap an input beat
    a_read_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        act.rd_en |-> !s_ready)
        else $error("ram read issued while taking input");

    // a move always restarts the window scan
    a_move_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        act.move |=> (step == ST_ROUND))
        else $error("move did not restart the round");

    // an emitted result shows up on the output channel
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        act.emit |=> m_valid)
        else $error("emitted result not presented");

    // an in-grid climb start leaves the idle step
    a_climb_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_op && stat.start_ok) |=> (step == ST_ROUND))
        else $error("climb start did not begin a round");

endmodule

/* verif/grid_local_maximum_climb_core_test.sv */
// ----------------------------------------------------------------------------
// grid_local_maximum_climb_core_test
// self-checking bench for the 8-neighbor hill climb core
// ----------------------------------------------------------------------------
// the whole grid is loaded first so that no climb can read an unloaded cell.
// a short table then exercises plateaus, corners, edges, ties and chained
// moves, followed by random scenes: hills, rising ridges, noise loads and
// stray climbs. every climb beat is matched against a hand-typed summit or a
// local climb predictor, with both channels idling at random and two long output hold-offs.
// ----------------------------------------------------------------------------
module grid_local_maximum_climb_core_test
    import glm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_CLIMB = 1'b1
    } grid_op_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PULSE,
        RX_SPARSE
    } rx_mode_t;

    typedef struct packed {
        logic [COORD_W-1:0]         end_row;
        logic [COORD_W-1:0]         end_col;
        logic signed [HEIGHT_W-1:0] peak;
        logic [MOVES_W-1:0]         moves;
    } summit_t;

    // one row of the directed table; known marks a summit typed in by hand
    typedef struct packed {
        grid_op_t            op;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [HEIGHT_W-1:0] height;
        logic                known;
        summit_t             want;
    } plan_row_t;

    localparam summit_t NO_SUMMIT     = '0;
    localparam int      PLAN_LEN      = 25;
    localparam int      RANDOM_ITEMS  = 330;
    localparam int      HOLD_CYCLES   = 400;
    localparam int      IDLE_LIMIT    = 20000;
    localparam int      DRAIN_CYCLES  = 64;
    localparam int      REPORT_LIMIT  = 10;

    // grid starts as a flat plain at the lowest height
    localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
        '{OP_CLIMB, 4'd0,  4'd0,  16'hffff, 1'b1, '{4'd0,  4'd0,  16'h8000, 8'd0}},
        '{OP_CLIMB, 4'd15, 4'd15, 16'h0000, 1'b1, '{4'd15, 4'd15, 16'h8000, 8'd0}},
        '{OP_LOAD,  4'd7,  4'd7,  16'h7fff, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd7,  4'd7,  16'h8000, 1'b1, '{4'd7,  4'd7,  16'h7fff, 8'd0}},
        '{OP_CLIMB, 4'd6,  4'd6,  16'h1234, 1'b1, '{4'd7,  4'd7,  16'h7fff, 8'd1}},
        '{OP_CLIMB, 4'd8,  4'd8,  16'hedcb, 1'b1, '{4'd7,  4'd7,  16'h7fff, 8'd1}},
        '{OP_CLIMB, 4'd6,  4'd8,  16'h0f0f, 1'b1, '{4'd7,  4'd7,  16'h7fff, 8'd1}},
        '{OP_LOAD,  4'd0,  4'd0,  16'h0064, 1'b0, NO_SUMMIT},
        '{OP_LOAD,  4'd0,  4'd1,  16'h0064, 1'b0, NO_SUMMIT},
        // equal heights never replace the candidate
        '{OP_CLIMB, 4'd1,  4'd1,  16'hf0f0, 1'b1, '{4'd0,  4'd0,  16'h0064, 8'd1}},
        '{OP_CLIMB, 4'd0,  4'd1,  16'h5a5a, 1'b1, '{4'd0,  4'd1,  16'h0064, 8'd0}},
        // corner and edge windows
        '{OP_LOAD,  4'd15, 4'd0,  16'hffff, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd14, 4'd1,  16'ha5a5, 1'b1, '{4'd15, 4'd0,  16'hffff, 8'd1}},
        '{OP_LOAD,  4'd0,  4'd15, 16'h0000, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd1,  4'd14, 16'h3c3c, 1'b1, '{4'd0,  4'd15, 16'h0000, 8'd1}},
        // two-step chain along the diagonal
        '{OP_LOAD,  4'd3,  4'd3,  16'h0001, 1'b0, NO_SUMMIT},
        '{OP_LOAD,  4'd4,  4'd4,  16'h0002, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd2,  4'd2,  16'hc3c3, 1'b1, '{4'd4,  4'd4,  16'h0002, 8'd2}},
        '{OP_LOAD,  4'd5,  4'd5,  16'h5555, 1'b0, NO_SUMMIT},
        '{OP_LOAD,  4'd6,  4'd6,  16'haaaa, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd4,  4'd4,  16'h7777, 1'b1, '{4'd5,  4'd5,  16'h5555, 8'd1}},
        // the rest are left to the predictor
        '{OP_CLIMB, 4'd5,  4'd6,  16'h8888, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd15, 4'd8,  16'h0001, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd8,  4'd15, 16'hfffe, 1'b0, NO_SUMMIT},
        '{OP_CLIMB, 4'd0,  4'd7,  16'h4000, 1'b0, NO_SUMMIT}
    };

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_op;
    logic [COORD_W-1:0]         s_cell_row;
    logic [COORD_W-1:0]         s_cell_col;
    logic signed [HEIGHT_W-1:0] s_height;
    logic                       m_valid;
    logic                       m_ready;
    logic [COORD_W-1:0]         m_end_row;
    logic [COORD_W-1:0]         m_end_col;
    logic signed [HEIGHT_W-1:0] m_peak_height;
    logic [MOVES_W-1:0]         m_move_count;

    // predictor copy of the grid and the summits still owed by the block
    logic signed [HEIGHT_W-1:0] height_map [GRID_ROWS][GRID_COLS];
    summit_t                    pending_summits [$];

    int errors;
    int beats_sent;
    int loads_sent;
    int climbs_sent;
    int summits_seen;
    int longest_climb;
    int stall_cycles;
    int blocked_cycles;
    int idle_cycles;
    int holds_done;
    int burst_left;

    grid_local_maximum_climb_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .s_height      (s_height),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_end_row     (m_end_row),
        .m_end_col     (m_end_col),
        .m_peak_height (m_peak_height),
        .m_move_count  (m_move_count)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // climb from a start cell over the predictor grid: each round scans the
    // fixed 3x3 window in row-major order, strictly higher cells win
    function automatic summit_t predict_summit(logic [COORD_W-1:0] row,
                                               logic [COORD_W-1:0] col);
        summit_t                    s;
        int                         pr;
        int                         pc;
        int                         br;
        int                         bc;
        int                         nr;
        int                         nc;
        int                         mv;
        logic signed [HEIGHT_W-1:0] bh;
        bit                         moved;
        s = '{end_row: row, end_col: col, peak: '0, moves: '0};
        // a start outside the grid reports at once
        if (int'(row) < GRID_ROWS && int'(col) < GRID_COLS) begin
            pr = row;
            pc = col;
            mv = 0;
            do begin
                br = pr;
                bc = pc;
                bh = height_map[pr][pc];
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        nr = pr + dr;
                        nc = pc + dc;
                        // cells off the grid are skipped
                        if (nr >= 0 && nc >= 0 && nr < GRID_ROWS && nc < GRID_COLS) begin
                            if (height_map[nr][nc] > bh) begin
                                bh = height_map[nr][nc];
                                br = nr;
                                bc = nc;
                            end
                        end
                    end
                end
                moved = (br != pr) || (bc != pc);
                if (moved) begin
                    pr = br;
                    pc = bc;
                    // count saturates
                    if (mv < int'(MOVES_MAX)) mv++;
                end
            end while (moved);
            s.end_row = COORD_W'(pr);
            s.end_col = COORD_W'(pc);
            s.peak    = bh;
            s.moves   = MOVES_W'(mv);
        end
        return s;
    endfunction

    function automatic int clamp_coord(int v, int top);
        if (v < 0) return 0;
        if (v > top - 1) return top - 1;
        return v;
    endfunction

    // present one beat at the falling edge, hold it until taken, then update
    // the predictor grid or queue the summit the climb must reach
    task automatic offer_beat(grid_op_t op, int row, int col,
                              logic [HEIGHT_W-1:0] height,
                              logic known, summit_t want);
        // sender bursts: a random gap before each new burst
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_valid    = 1'b1;
        s_op       = op;
        s_cell_row = COORD_W'(row);
        s_cell_col = COORD_W'(col);
        s_height   = height;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (op == OP_LOAD) begin
            loads_sent++;
            // loads outside the grid are dropped
            if (row < GRID_ROWS && col < GRID_COLS) height_map[row][col] = height;
        end else begin
            climbs_sent++;
            pending_summits.push_back(known ? want
                                            : predict_summit(COORD_W'(row), COORD_W'(col)));
        end
        @(negedge aclk);
    endtask

    // result checker, stall counters and watchdog
    always @(posedge aclk) begin : watch_summits
        summit_t want;
        if (aresetn) begin
            if (s_valid && !s_ready) blocked_cycles++;
            if (m_valid && !m_ready) stall_cycles++;
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_valid && m_ready) begin
                summits_seen++;
                if (int'(m_move_count) > longest_climb) longest_climb = m_move_count;
                if (pending_summits.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected summit beat row %0d col %0d peak %0d moves %0d",
                                 $realtime, m_end_row, m_end_col, m_peak_height,
                                 m_move_count);
                end else begin
                    want = pending_summits.pop_front();
                    if (m_end_row !== want.end_row || m_end_col !== want.end_col ||
                        m_peak_height !== want.peak || m_move_count !== want.moves) begin
                        errors++;
                        if (errors <= REPORT_LIMIT) begin
                            $display("%0t: summit mismatch on climb result %0d", $realtime,
                                     summits_seen);
                            $display("    expected row %0d col %0d peak %0d moves %0d",
                                     want.end_row, want.end_col, want.peak, want.moves);
                            $display("    actual   row %0d col %0d peak %0d moves %0d",
                                     m_end_row, m_end_col, m_peak_height, m_move_count);
                        end
                    end
                end
            end
            // nothing moved on either channel for far too long
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat on either channel for %0d cycles", $realtime,
                         IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random pattern modes, plus long hold-offs so the block backs up
    initial begin : ready_pattern
        rx_mode_t mode;
        int       run_left;
        int       phase;
        m_ready  = 1'b0;
        mode     = RX_ALWAYS;
        run_left = 0;
        phase    = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (holds_done < 2 && summits_seen >= 30 + 70 * holds_done) begin
                // hold-off counted here while the sender keeps offering
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end
            if (run_left == 0) begin
                mode     = rx_mode_t'($urandom_range(0, 3));
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            phase++;
            case (mode)
                RX_ALWAYS: m_ready = 1'b1;
                RX_COIN:   m_ready = $urandom_range(0, 1);
                RX_PULSE:  m_ready = (phase % 3) != 0;
                default:   m_ready = $urandom_range(0, 3) == 0;
            endcase
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin : drive_items
        int cr;
        int cc;
        int r;
        int c;
        int pick;
        int reach;
        int peak;
        int slope;
        int h;
        int len;
        int dr;
        int dc;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_LOAD;
        s_cell_row     = '0;
        s_cell_col     = '0;
        s_height       = '0;
        errors         = 0;
        beats_sent     = 0;
        loads_sent     = 0;
        climbs_sent    = 0;
        summits_seen   = 0;
        longest_climb  = 0;
        stall_cycles   = 0;
        blocked_cycles = 0;
        idle_cycles    = 0;
        holds_done     = 0;
        burst_left     = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // flat plain at the lowest height so every later read hits a loaded cell
        for (int i = 0; i < GRID_ROWS; i++)
            for (int j = 0; j < GRID_COLS; j++)
                offer_beat(OP_LOAD, i, j, 16'h8000, 1'b0, NO_SUMMIT);

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
            offer_beat(PLAN[i].op, PLAN[i].row, PLAN[i].col, PLAN[i].height,
                       PLAN[i].known, PLAN[i].want);

        // random scenes
        while (beats_sent < GRID_ROWS * GRID_COLS + PLAN_LEN + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // hill: heights fall off by chebyshev distance from the top
                cr    = $urandom_range(0, GRID_ROWS - 1);
                cc    = $urandom_range(0, GRID_COLS - 1);
                reach = ($urandom_range(0, 3) == 0) ? 2 : 1;
                peak  = $urandom_range(0, 52767) - 20000;
                slope = $urandom_range(1, 3000);
                for (int i = -reach; i <= reach; i++) begin
                    for (int j = -reach; j <= reach; j++) begin
                        r = cr + i;
                        c = cc + j;
                        h = peak - slope * ((i < 0 ? -i : i) > (j < 0 ? -j : j) ?
                                            (i < 0 ? -i : i) : (j < 0 ? -j : j));
                        if (r >= 0 && c >= 0 && r < GRID_ROWS && c < GRID_COLS)
                            offer_beat(OP_LOAD, r, c, HEIGHT_W'(h), 1'b0, NO_SUMMIT);
                    end
                end
                repeat ($urandom_range(2, 4)) begin
                    r = clamp_coord(cr + $urandom_range(0, 8) - 4, GRID_ROWS);
                    c = clamp_coord(cc + $urandom_range(0, 8) - 4, GRID_COLS);
                    offer_beat(OP_CLIMB, r, c, HEIGHT_W'($urandom()), 1'b0, NO_SUMMIT);
                end
            end else if (pick < 75) begin
                // ridge: random walk with strictly rising heights, climbed from its foot
                cr  = $urandom_range(0, GRID_ROWS - 1);
                cc  = $urandom_range(0, GRID_COLS - 1);
                r   = cr;
                c   = cc;
                h   = $urandom_range(0, 30000) - 30000;
                len = $urandom_range(4, 24);
                offer_beat(OP_LOAD, r, c, HEIGHT_W'(h), 1'b0, NO_SUMMIT);
                repeat (len) begin
                    dr = $urandom_range(0, 2) - 1;
                    dc = $urandom_range(0, 2) - 1;
                    if (dr == 0 && dc == 0) dc = 1;
                    r = clamp_coord(r + dr, GRID_ROWS);
                    c = clamp_coord(c + dc, GRID_COLS);
                    h = h + $urandom_range(1, 800);
                    offer_beat(OP_LOAD, r, c, HEIGHT_W'(h), 1'b0, NO_SUMMIT);
                end
                offer_beat(OP_CLIMB, cr, cc, HEIGHT_W'($urandom()), 1'b0, NO_SUMMIT);
                if ($urandom_range(0, 1))
                    offer_beat(OP_CLIMB, $urandom_range(0, GRID_ROWS - 1),
                               $urandom_range(0, GRID_COLS - 1), HEIGHT_W'($urandom()),
                               1'b0, NO_SUMMIT);
            end else if (pick < 90) begin
                // noise: loads of any height anywhere, then one climb
                repeat ($urandom_range(1, 6))
                    offer_beat(OP_LOAD, $urandom_range(0, GRID_ROWS - 1),
                               $urandom_range(0, GRID_COLS - 1), HEIGHT_W'($urandom()),
                               1'b0, NO_SUMMIT);
                offer_beat(OP_CLIMB, $urandom_range(0, GRID_ROWS - 1),
                           $urandom_range(0, GRID_COLS - 1), HEIGHT_W'($urandom()),
                           1'b0, NO_SUMMIT);
            end else begin
                // back-to-back climbs from anywhere
                repeat ($urandom_range(1, 4))
                    offer_beat(OP_CLIMB, $urandom_range(0, GRID_ROWS - 1),
                               $urandom_range(0, GRID_COLS - 1), HEIGHT_W'($urandom()),
                               1'b0, NO_SUMMIT);
            end
        end
        s_valid = 1'b0;

        // drain, then give a stray extra beat the chance to show up
        while (pending_summits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_summits.size() != 0) begin
            errors++;
            $display("%0d climbs never reported a summit", pending_summits.size());
        end

        $display("covered %0d loads and %0d climbs, %0d summits checked, longest climb %0d moves",
                 loads_sent, climbs_sent, summits_seen, longest_climb);
        $display("output stalled %0d cycles (%0d long hold-offs), input blocked %0d cycles",
                 stall_cycles, holds_done, blocked_cycles);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/glm_pkg.sv
hdl/glm_ram.sv
hdl/glm_useq.sv
hdl/glm_datapath.sv
hdl/grid_local_maximum_climb_core.sv
verif/grid_local_maximum_climb_core_test.sv
